// ----- rtl/rfre_pkg.sv -----
// ----------------------------------------------------------------------------
// rfre_pkg
// Shared types and constants of the radar first return extractor.
// ----------------------------------------------------------------------------
package rfre_pkg;

    localparam int SLOTS_PER_TURN  = 400;
    localparam int ENCODER_COUNTS  = 5600;
    localparam int MAX_BINS        = 4096;

    localparam int ANGLE_DIV_RAW = ENCODER_COUNTS / SLOTS_PER_TURN;
    localparam int ANGLE_DIV     = (ANGLE_DIV_RAW == 0) ? 1 : ANGLE_DIV_RAW;
    // ceil(2^32 / div): exact quotient for any 16-bit count
    localparam longint unsigned ANGLE_RECIP_L =
        ((64'd1 << 32) + 64'(ANGLE_DIV) - 64'd1) / 64'(ANGLE_DIV);
    localparam logic [32:0] ANGLE_RECIP = ANGLE_RECIP_L[32:0];

    localparam logic [16:0] AZ_SAMPLES_W = 17'(SLOTS_PER_TURN);
    localparam logic [12:0] BIN_MAX      = 13'h1FFF;
    localparam logic [28:0] DIST_MAX     = 29'h1FFF_FFFF;

    localparam int LINE_QUEUE_DEPTH = 4;
    localparam int LINE_QUEUE_PTR_W = $clog2(LINE_QUEUE_DEPTH);

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_FIRST_BIN        = 3'd0;
    localparam logic [2:0] REG_LAST_BIN         = 3'd1;
    localparam logic [2:0] REG_RETURN_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_FIRST_AZIMUTH    = 3'd3;
    localparam logic [2:0] REG_END_AZ_LIMIT     = 3'd4;
    localparam logic [2:0] REG_INDEX_OFFSET     = 3'd5;
    localparam logic [2:0] REG_BIN_LENGTH       = 3'd6;
    localparam logic [2:0] REG_DISTANCE_OFFSET  = 3'd7;

    typedef struct packed {
        logic [12:0] first_bin;
        logic [12:0] last_bin;
        logic [7:0]  return_threshold;
        logic [8:0]  first_azimuth;
        logic [8:0]  end_azimuth_limit;
        logic [8:0]  index_offset;
        logic [15:0] bin_length;
        logic [23:0] distance_offset;
    } rfre_cfg_t;

    // one finished line handed from front to back
    typedef struct packed {
        logic [12:0] chosen_bin;
        logic [7:0]  strength;
        logic [15:0] encoder_angle;
    } rfre_line_t;

endpackage

// ----- rtl/rfre_if.sv -----
// ----------------------------------------------------------------------------
// rfre_if
// Valid/ready channels: FFT bin requests in, line result requests out.
// ----------------------------------------------------------------------------
interface rfre_bin_if;
    logic        valid;
    logic        ready;
    logic [7:0]  bin_power;
    logic [15:0] encoder_angle;
    logic        line_end;

    modport source (output valid, output bin_power, output encoder_angle,
                    output line_end, input ready);
    modport sink   (input valid, input bin_power, input encoder_angle,
                    input line_end, output ready);
endinterface

interface rfre_result_if;
    logic        valid;
    logic        ready;
    logic [8:0]  scan_slot;
    logic [28:0] distance;
    logic [7:0]  strength;
    logic        turn_complete;

    modport source (output valid, output scan_slot, output distance,
                    output strength, output turn_complete, input ready);
    modport sink   (input valid, input scan_slot, input distance,
                    input strength, input turn_complete, output ready);
endinterface

// ----- rtl/rfre_front.sv -----
// ----------------------------------------------------------------------------
// rfre_front
// Bin search: tracks bin index and first return, emits one line record.
// ----------------------------------------------------------------------------
module rfre_front
    import rfre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rfre_cfg_t         cfg,
    rfre_bin_if.sink          bin_in,
    input  logic              queue_full,
    output logic              push,
    output rfre_line_t        line
);

    logic [12:0] bin_count_reg, bin_count_next;
    logic        hit_seen_reg, hit_seen_next;
    logic [12:0] hit_bin_reg, hit_bin_next;
    logic [7:0]  hit_power_reg, hit_power_next;

    logic        accept;
    logic        qualify;
    logic [12:0] window_top;
    logic [13:0] line_len;
    logic [13:0] lim;
    logic [12:0] fallback_bin;

    assign bin_in.ready = !queue_full;
    assign accept       = bin_in.valid && bin_in.ready;

    assign window_top = (cfg.first_bin > cfg.last_bin) ? cfg.first_bin : cfg.last_bin;
    assign qualify    = (bin_count_reg >= cfg.first_bin) && (bin_count_reg < cfg.last_bin)
                        && (bin_in.bin_power > cfg.return_threshold);

    always_comb
    begin
        hit_seen_next  = hit_seen_reg;
        hit_bin_next   = hit_bin_reg;
        hit_power_next = hit_power_reg;
        if (!hit_seen_reg)
        begin
            if (qualify)
            begin
                hit_seen_next  = 1'b1;
                hit_bin_next   = bin_count_reg;
                hit_power_next = bin_in.bin_power;
            end
            else if (bin_count_reg == window_top)
            begin
                hit_power_next = bin_in.bin_power;
            end
        end
    end

    assign line_len     = 14'(bin_count_reg) + 14'd1;
    assign lim          = (line_len < 14'(cfg.last_bin)) ? line_len : 14'(cfg.last_bin);
    assign fallback_bin = (14'(cfg.first_bin) > lim) ? cfg.first_bin : lim[12:0];

    always_comb
    begin
        line.encoder_angle = bin_in.encoder_angle;
        if (hit_seen_next)
        begin
            line.chosen_bin = hit_bin_next;
            line.strength   = hit_power_next;
        end
        else
        begin
            line.chosen_bin = fallback_bin;
            line.strength   = (14'(fallback_bin) < line_len) ? hit_power_next : 8'd0;
        end
    end

    assign push = accept && bin_in.line_end;

    assign bin_count_next = (bin_count_reg < BIN_MAX) ? bin_count_reg + 13'd1 : bin_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= '0;
            hit_seen_reg  <= 1'b0;
            hit_bin_reg   <= '0;
            hit_power_reg <= '0;
        end
        else if (accept)
        begin
            if (bin_in.line_end)
            begin
                bin_count_reg <= '0;
                hit_seen_reg  <= 1'b0;
                hit_bin_reg   <= '0;
                hit_power_reg <= '0;
            end
            else
            begin
                bin_count_reg <= bin_count_next;
                hit_seen_reg  <= hit_seen_next;
                hit_bin_reg   <= hit_bin_next;
                hit_power_reg <= hit_power_next;
            end
        end
    end

endmodule

// ----- rtl/rfre_fifo.sv -----
// ----------------------------------------------------------------------------
// rfre_fifo
// Short queue of finished line records between front and back.
// ----------------------------------------------------------------------------
module rfre_fifo
    import rfre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rfre_line_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output rfre_line_t head
);

    rfre_line_t entry_reg [LINE_QUEUE_DEPTH];

    logic [LINE_QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [LINE_QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [LINE_QUEUE_PTR_W:0]   count_reg;

    assign full      = (count_reg == (LINE_QUEUE_PTR_W+1)'(LINE_QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rfre_back.sv -----
// ----------------------------------------------------------------------------
// rfre_back
// Result path: azimuth index, range multiply, windowing, output register.
// ----------------------------------------------------------------------------
module rfre_back
    import rfre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rfre_cfg_t     cfg,
    input  logic          line_avail,
    input  rfre_line_t    head,
    output logic          pop,
    rfre_result_if.source result_out
);

    logic        s1_valid_reg;
    logic [15:0] s1_idx_reg;
    logic [29:0] s1_prod_reg;
    logic [7:0]  s1_strength_reg;

    logic        out_valid_reg;
    logic [8:0]  out_slot_reg;
    logic [28:0] out_distance_reg;
    logic [7:0]  out_strength_reg;
    logic        out_turn_reg;

    logic [8:0]  previous_index_reg, previous_index_next;

    logic        advance;
    logic [48:0] idx_prod;
    logic [13:0] chosen_p1;
    logic [29:0] dist_prod;
    logic [16:0] slot_sum;
    logic [16:0] slot_wrap;
    logic [30:0] dist_sum;
    logic [28:0] dist_sat;
    logic        az_in_window;

    assign advance = !out_valid_reg || result_out.ready;
    assign pop     = advance && line_avail;

    assign idx_prod  = 49'(head.encoder_angle) * 49'(ANGLE_RECIP);
    assign chosen_p1 = 14'(head.chosen_bin) + 14'd1;
    assign dist_prod = 30'(cfg.bin_length) * 30'(chosen_p1);

    assign slot_sum     = 17'(s1_idx_reg) + 17'(cfg.index_offset);
    assign slot_wrap    = (slot_sum >= AZ_SAMPLES_W) ? slot_sum - AZ_SAMPLES_W : slot_sum;
    assign dist_sum     = 31'(s1_prod_reg) + 31'(cfg.distance_offset);
    assign dist_sat     = (dist_sum > 31'(DIST_MAX)) ? DIST_MAX : dist_sum[28:0];
    assign az_in_window = (s1_idx_reg >= 16'(cfg.first_azimuth))
                          && (s1_idx_reg < 16'(cfg.end_azimuth_limit));
    assign previous_index_next = (|s1_idx_reg[15:9]) ? 9'h1FF : s1_idx_reg[8:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_idx_reg       <= idx_prod[47:32];
            s1_prod_reg      <= dist_prod;
            s1_strength_reg  <= head.strength;
            out_slot_reg     <= slot_wrap[8:0];
            out_distance_reg <= az_in_window ? dist_sat : 29'd0;
            out_strength_reg <= az_in_window ? s1_strength_reg : 8'd0;
            out_turn_reg     <= (s1_idx_reg < 16'(previous_index_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            previous_index_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= line_avail;
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                previous_index_reg <= previous_index_next;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.scan_slot     = out_slot_reg;
    assign result_out.distance      = out_distance_reg;
    assign result_out.strength      = out_strength_reg;
    assign result_out.turn_complete = out_turn_reg;

endmodule

// ----- rtl/radar_first_return_extractor_core.sv -----
// ----------------------------------------------------------------------------
// radar_first_return_extractor_core
// First return per azimuth line from a stream of FFT power bins.
//
//   channel     dir  handshake       payload
//   bin_in      in   valid/ready     bin_power, encoder_angle, line_end
//   result_out  out  valid/ready     scan_slot, distance, strength, turn_complete
//   apb         in   psel/penable    8 registers at 4*i, pready tied high
//
// One bin request per cycle while the line queue is not full. A line result
// passes through the queue, the multiply stage and the output register. Reset
// clears counters and queue and sets the config registers to defaults. A stalled
// output fills the 4-entry line queue; bins are held off only when it is full.
// ----------------------------------------------------------------------------
module radar_first_return_extractor_core
    import rfre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    rfre_bin_if.sink              bin_in,
    rfre_result_if.source         result_out
);

    rfre_cfg_t  cfg_reg;
    logic       cfg_write;
    logic [2:0] reg_sel;

    logic       queue_full;
    logic       queue_avail;
    logic       push;
    logic       pop;
    rfre_line_t push_line;
    rfre_line_t head_line;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_bin         <= '0;
            cfg_reg.last_bin          <= 13'(MAX_BINS);
            cfg_reg.return_threshold  <= 8'd127;
            cfg_reg.first_azimuth     <= '0;
            cfg_reg.end_azimuth_limit <= 9'(SLOTS_PER_TURN);
            cfg_reg.index_offset      <= '0;
            cfg_reg.bin_length        <= '0;
            cfg_reg.distance_offset   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_FIRST_BIN:        cfg_reg.first_bin         <= pwdata[12:0];
                REG_LAST_BIN:         cfg_reg.last_bin          <= pwdata[12:0];
                REG_RETURN_THRESHOLD: cfg_reg.return_threshold  <= pwdata[7:0];
                REG_FIRST_AZIMUTH:    cfg_reg.first_azimuth     <= pwdata[8:0];
                REG_END_AZ_LIMIT:     cfg_reg.end_azimuth_limit <= pwdata[8:0];
                REG_INDEX_OFFSET:     cfg_reg.index_offset      <= pwdata[8:0];
                REG_BIN_LENGTH:       cfg_reg.bin_length        <= pwdata[15:0];
                REG_DISTANCE_OFFSET:  cfg_reg.distance_offset   <= pwdata[23:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FIRST_BIN:        prdata = 32'(cfg_reg.first_bin);
            REG_LAST_BIN:         prdata = 32'(cfg_reg.last_bin);
            REG_RETURN_THRESHOLD: prdata = 32'(cfg_reg.return_threshold);
            REG_FIRST_AZIMUTH:    prdata = 32'(cfg_reg.first_azimuth);
            REG_END_AZ_LIMIT:     prdata = 32'(cfg_reg.end_azimuth_limit);
            REG_INDEX_OFFSET:     prdata = 32'(cfg_reg.index_offset);
            REG_BIN_LENGTH:       prdata = 32'(cfg_reg.bin_length);
            REG_DISTANCE_OFFSET:  prdata = 32'(cfg_reg.distance_offset);
            default:              prdata = '0;
        endcase
    end

    rfre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .bin_in     (bin_in),
        .queue_full (queue_full),
        .push       (push),
        .line       (push_line)
    );

    rfre_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_line),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_avail),
        .head      (head_line)
    );

    rfre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .line_avail (queue_avail),
        .head       (head_line),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
